@@ rtl/tcce_pkg.sv @@
`default_nettype none

package tcce_pkg;

    // Field widths
    localparam int CODE_W     = 8;
    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // Default tab stop spacing
    localparam int TAB_WIDTH_DEF = 8;

    // Control characters
    localparam logic [CODE_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_RETURN  = 8'd13;

    // Screen size after reset
    localparam logic [POS_W-1:0] ROWS_RESET = 8'd25;
    localparam logic [POS_W-1:0] COLS_RESET = 8'd80;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_ROWS    = 8'd0,
        REG_SCREEN_COLUMNS = 8'd1
    } t_reg_index;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_cursor;

    typedef struct packed {
        logic              write_valid;
        logic [POS_W-1:0]  write_row;
        logic [POS_W-1:0]  write_col;
        logic [CODE_W-1:0] write_glyph;
        logic              scroll_up;
        logic [POS_W-1:0]  cursor_row;
        logic [POS_W-1:0]  cursor_col;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/tcce_if.sv @@
`default_nettype none

// Character request channel
interface tcce_char_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

// Result channel
interface tcce_result_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              write_valid;
    logic [POS_W-1:0]  write_row;
    logic [POS_W-1:0]  write_col;
    logic [CODE_W-1:0] write_glyph;
    logic              scroll_up;
    logic [POS_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_col;

    modport source (output valid, output write_valid, output write_row, output write_col,
                    output write_glyph, output scroll_up, output cursor_row,
                    output cursor_col, input ready);
    modport sink   (input valid, input write_valid, input write_row, input write_col,
                    input write_glyph, input scroll_up, input cursor_row,
                    input cursor_col, output ready);
endinterface

// Configuration write channel
interface tcce_cfg_if import tcce_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

@@ rtl/tcce_cursor_step.sv @@
`default_nettype none

module tcce_cursor_step import tcce_pkg::*; #(
    parameter int TAB_WIDTH = TAB_WIDTH_DEF,
    parameter int PH_W      = 3
) (
    input  wire logic [CODE_W-1:0] i_code,
    input  wire t_cursor           i_cursor,
    input  wire logic [PH_W-1:0]   i_phase,
    input  wire logic [POS_W-1:0]  i_rows,
    input  wire logic [POS_W-1:0]  i_cols,
    output t_cursor                o_cursor,
    output logic [PH_W-1:0]        o_phase,
    output t_result                o_result
);

    localparam logic [POS_W-1:0] TAB_POS  = POS_W'(TAB_WIDTH);
    localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(TAB_WIDTH - 1);

    logic [POS_W-1:0] w_eff_rows;
    logic [POS_W-1:0] w_eff_cols;
    logic [POS_W-1:0] w_last_row;
    logic             w_at_last;
    logic [POS_W-1:0] w_row_next;
    logic [POS_W:0]   w_col_inc;
    logic             w_col_wrap;
    logic [PH_W-1:0]  w_phase_inc;
    logic [POS_W:0]   w_tab_target;
    logic             w_tab_wrap;
    logic [POS_W:0]   w_tab_rem;

    // Clamp the screen size to its usable range
    assign w_eff_rows = (i_rows == '0) ? POS_W'(1) : i_rows;
    assign w_eff_cols = (i_cols < TAB_POS) ? TAB_POS : i_cols;
    assign w_last_row = w_eff_rows - POS_W'(1);

    // Next row, held on the last row when a scroll is due
    assign w_at_last  = (i_cursor.row >= w_last_row);
    assign w_row_next = w_at_last ? w_last_row : i_cursor.row + POS_W'(1);

    // One column forward
    assign w_col_inc   = {1'b0, i_cursor.col} + (POS_W+1)'(1);
    assign w_col_wrap  = (w_col_inc >= {1'b0, w_eff_cols});
    assign w_phase_inc = (i_phase == PH_LAST) ? '0 : i_phase + PH_W'(1);

    // Tab target; a tab wraps at most once since the row is at least a tab wide
    assign w_tab_target = {1'b0, i_cursor.col} + (POS_W+1)'(TAB_WIDTH)
                          - (POS_W+1)'(i_phase);
    assign w_tab_wrap   = (w_tab_target >= {1'b0, w_eff_cols});
    assign w_tab_rem    = w_tab_target - {1'b0, w_eff_cols};

    always_comb begin
        o_cursor             = i_cursor;
        o_phase              = i_phase;
        o_result.write_valid = 1'b0;
        o_result.write_row   = '0;
        o_result.write_col   = '0;
        o_result.write_glyph = '0;
        o_result.scroll_up   = 1'b0;

        unique case (i_code)
            CHAR_NEWLINE: begin
                o_cursor.row       = w_row_next;
                o_cursor.col       = '0;
                o_phase            = '0;
                o_result.scroll_up = w_at_last;
            end
            CHAR_RETURN: begin
                // leave the cursor where it is
            end
            CHAR_TAB: begin
                if (w_tab_wrap) begin
                    o_cursor.row       = w_row_next;
                    o_cursor.col       = w_tab_rem[POS_W-1:0];
                    o_phase            = w_tab_rem[PH_W-1:0];
                    o_result.scroll_up = w_at_last;
                end else begin
                    o_cursor.col = w_tab_target[POS_W-1:0];
                    o_phase      = '0;
                end
            end
            default: begin
                o_result.write_valid = 1'b1;
                o_result.write_row   = i_cursor.row;
                o_result.write_col   = i_cursor.col;
                o_result.write_glyph = i_code;
                if (w_col_wrap) begin
                    o_cursor.row       = w_row_next;
                    o_cursor.col       = '0;
                    o_phase            = '0;
                    o_result.scroll_up = w_at_last;
                end else begin
                    o_cursor.col = w_col_inc[POS_W-1:0];
                    o_phase      = w_phase_inc;
                end
            end
        endcase

        o_result.cursor_row = o_cursor.row;
        o_result.cursor_col = o_cursor.col;
    end

endmodule

`default_nettype wire

@@ rtl/text_console_cursor_engine_core.sv @@
`default_nettype none

// Text console cursor engine: takes one character per request on i_char and returns one
// result per character on o_result, carrying the glyph write (cell row, column, code), a
// one-row scroll flag and the cursor after the character. Newline goes to column 0 of the
// next row, carriage return changes nothing, tab advances to the next tab stop, and any
// other code is written at the cursor before it advances; wrapping past the last row
// raises scroll_up and parks the cursor on the last row. The block accepts one character
// per clock. An accepted request lands in the input register, and its result is loaded
// into the result register once that register is free or being emptied, and is shown on
// o_result from there. The rate is set by the cursor and tab-phase registers, which are
// updated by combinational logic for every character. While a result waits, the input
// register holds its character and i_char.ready drops, so at most two characters are
// held inside the block. Writing the row or column count on i_cfg homes the cursor;
// writes to other indexes are dropped. Sizes reset to 25 rows by 80 columns.
module text_console_cursor_engine_core import tcce_pkg::*; #(
    parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tcce_char_if.sink      i_char,
    tcce_cfg_if.sink       i_cfg,
    tcce_result_if.source  o_result
);

    localparam int PH_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

    logic [POS_W-1:0]  r_rows;
    logic [POS_W-1:0]  r_cols;
    t_cursor           r_cursor;
    logic [PH_W-1:0]   r_phase;
    logic              r_s1_valid;
    logic [CODE_W-1:0] r_s1_code;
    logic              r_out_valid;
    t_result           r_out;

    t_cursor           n_cursor;
    logic [PH_W-1:0]   n_phase;
    t_result           n_out;

    logic w_out_free;
    logic w_adv;
    logic w_in_acc;
    logic w_cfg_wr;
    logic w_cfg_hit;

    // Handshakes
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_adv        = r_s1_valid && w_out_free;
    assign i_char.ready = !r_s1_valid || w_adv;
    assign w_in_acc     = i_char.valid && i_char.ready;
    assign i_cfg.ready  = 1'b1;
    assign w_cfg_wr     = i_cfg.valid && i_cfg.ready;
    assign w_cfg_hit    = (i_cfg.reg_index == REG_SCREEN_ROWS)
                       || (i_cfg.reg_index == REG_SCREEN_COLUMNS);

    // Cursor update for the character in the input register
    tcce_cursor_step #(
        .TAB_WIDTH (TAB_WIDTH),
        .PH_W      (PH_W)
    ) u_step (
        .i_code   (r_s1_code),
        .i_cursor (r_cursor),
        .i_phase  (r_phase),
        .i_rows   (r_rows),
        .i_cols   (r_cols),
        .o_cursor (n_cursor),
        .o_phase  (n_phase),
        .o_result (n_out)
    );

    // Control state: sizes, cursor, stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= ROWS_RESET;
            r_cols      <= COLS_RESET;
            r_cursor    <= '0;
            r_phase     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr && w_cfg_hit) begin
                if (i_cfg.reg_index == REG_SCREEN_ROWS) begin
                    r_rows <= i_cfg.write_data;
                end else begin
                    r_cols <= i_cfg.write_data;
                end
                r_cursor <= '0;
                r_phase  <= '0;
            end else if (w_adv) begin
                r_cursor <= n_cursor;
                r_phase  <= n_phase;
            end

            if (i_char.ready) begin
                r_s1_valid <= i_char.valid;
            end

            if (w_out_free) begin
                r_out_valid <= w_adv;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_code <= i_char.char_code;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // Drive the result channel
    assign o_result.valid       = r_out_valid;
    assign o_result.write_valid = r_out.write_valid;
    assign o_result.write_row   = r_out.write_row;
    assign o_result.write_col   = r_out.write_col;
    assign o_result.write_glyph = r_out.write_glyph;
    assign o_result.scroll_up   = r_out.scroll_up;
    assign o_result.cursor_row  = r_out.cursor_row;
    assign o_result.cursor_col  = r_out.cursor_col;

    // Tab phase stays below the tab width
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < PH_W'(TAB_WIDTH - 1) || r_phase == PH_W'(TAB_WIDTH - 1))
        else $error("tab phase out of range");

    // A stalled input register keeps its character
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_adv |=> r_s1_valid && $stable(r_s1_code))
        else $error("input register lost a stalled character");

    // Cursor moves only on a processed character or a size write
    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv && !w_cfg_wr |=> $stable(r_cursor) && $stable(r_phase))
        else $error("cursor changed without a request");

    // Control characters never produce a glyph write
    a_no_ctrl_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.write_valid |->
            r_out.write_glyph != CHAR_NEWLINE && r_out.write_glyph != CHAR_RETURN
            && r_out.write_glyph != CHAR_TAB)
        else $error("control character written as glyph");

endmodule

`default_nettype wire

@@ bench/text_console_cursor_engine_core_test.sv @@
`timescale 1ns / 1ps

module text_console_cursor_engine_core_test;
    import tcce_pkg::*;

    localparam int HOLD_CYCLES = 160;
    localparam int REPORT_LIMIT = 10;
    localparam logic [CFG_IDX_W-1:0] REG_BEYOND_MAP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

    // Cursor tracker: mirrors the row and column of the screen and keeps
    // the cursor updates still owed by the block, oldest first.
    class cursor_tracker;
        logic [POS_W-1:0] rows;
        logic [POS_W-1:0] cols;
        logic [POS_W-1:0] cur_row;
        logic [POS_W-1:0] cur_col;
        t_result cursor_updates[$];
        int unsigned mismatches;
        int unsigned orphans;
        int unsigned checked;
        int unsigned reported;

        function new();
            rows = ROWS_RESET;
            cols = COLS_RESET;
            cur_row = '0;
            cur_col = '0;
            mismatches = 0;
            orphans = 0;
            checked = 0;
            reported = 0;
        endfunction

        // Size writes home the cursor; unknown indexes are dropped.
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SCREEN_ROWS) begin
                rows = data;
            end else if (idx == REG_SCREEN_COLUMNS) begin
                cols = data;
            end else begin
                return;
            end
            cur_row = '0;
            cur_col = '0;
        endfunction

        // Move to the next row; past the last row, park there and scroll.
        function void step_row(inout int unsigned row, inout int unsigned col,
                               inout bit scroll);
            int unsigned last_row;
            last_row = (rows == 0) ? 0 : rows - 1;
            row = row + 1;
            if (row > last_row) begin
                row = last_row;
                col = 0;
                scroll = 1'b1;
            end
        endfunction

        // Advance one column, wrapping at the right edge.
        function void step_col(inout int unsigned row, inout int unsigned col,
                               inout bit scroll);
            int unsigned last_col;
            last_col = (cols < TAB_WIDTH_DEF) ? TAB_WIDTH_DEF - 1 : cols - 1;
            col = col + 1;
            if (col > last_col) begin
                col = 0;
                step_row(row, col, scroll);
            end
        endfunction

        // Work out the glyph write, scroll and new cursor for one character.
        function t_result apply_char(logic [CODE_W-1:0] code);
            t_result upd;
            int unsigned row;
            int unsigned col;
            int unsigned steps;
            bit scroll;
            upd = '0;
            scroll = 1'b0;
            row = cur_row;
            col = cur_col;
            case (code)
                CHAR_NEWLINE: begin
                    step_row(row, col, scroll);
                    col = 0;
                end
                CHAR_RETURN: begin
                end
                CHAR_TAB: begin
                    steps = TAB_WIDTH_DEF - (col % TAB_WIDTH_DEF);
                    repeat (steps) step_col(row, col, scroll);
                end
                default: begin
                    upd.write_valid = 1'b1;
                    upd.write_row = row[POS_W-1:0];
                    upd.write_col = col[POS_W-1:0];
                    upd.write_glyph = code;
                    step_col(row, col, scroll);
                end
            endcase
            cur_row = row[POS_W-1:0];
            cur_col = col[POS_W-1:0];
            upd.scroll_up = scroll;
            upd.cursor_row = cur_row;
            upd.cursor_col = cur_col;
            return upd;
        endfunction

        function void note_char(logic [CODE_W-1:0] code);
            cursor_updates.push_back(apply_char(code));
        endfunction

        function int unsigned pending();
            return cursor_updates.size();
        endfunction

        // Compare one returned result with the oldest owed update.
        function void check_result(t_result got);
            t_result want;
            if (cursor_updates.size() == 0) begin
                orphans++;
                reported++;
                if (reported <= REPORT_LIMIT)
                    $display("unexpected result: wv=%0b row=%0d col=%0d glyph=%0d scroll=%0b cursor=%0d,%0d",
                             got.write_valid, got.write_row, got.write_col, got.write_glyph,
                             got.scroll_up, got.cursor_row, got.cursor_col);
                return;
            end
            want = cursor_updates.pop_front();
            checked++;
            if (got.write_valid !== want.write_valid || got.write_row !== want.write_row ||
                got.write_col !== want.write_col || got.write_glyph !== want.write_glyph ||
                got.scroll_up !== want.scroll_up || got.cursor_row !== want.cursor_row ||
                got.cursor_col !== want.cursor_col) begin
                mismatches++;
                reported++;
                if (reported <= REPORT_LIMIT) begin
                    $display("result %0d mismatch", checked);
                    $display("  expected wv=%0b row=%0d col=%0d glyph=%0d scroll=%0b cursor=%0d,%0d",
                             want.write_valid, want.write_row, want.write_col, want.write_glyph,
                             want.scroll_up, want.cursor_row, want.cursor_col);
                    $display("  actual   wv=%0b row=%0d col=%0d glyph=%0d scroll=%0b cursor=%0d,%0d",
                             got.write_valid, got.write_row, got.write_col, got.write_glyph,
                             got.scroll_up, got.cursor_row, got.cursor_col);
                end
            end
        endfunction

        // Count everything wrong, including updates that never came back.
        function int unsigned failures();
            if (cursor_updates.size() != 0)
                $display("%0d results never returned", cursor_updates.size());
            return mismatches + orphans + cursor_updates.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int unsigned idle_pct;
    int unsigned stall_pct;
    bit hold_start;
    int unsigned hold_count;
    int unsigned chars_sent;
    int unsigned reg_writes;
    cursor_tracker tracker = new();

    tcce_char_if char_ch();
    tcce_cfg_if cfg_ch();
    tcce_result_if res_ch();

    text_console_cursor_engine_core dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_char   (char_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    always #6 clk = ~clk;

    // Drive result ready: a long hold-off once requested, else random stalls.
    always @(posedge clk) begin
        if (hold_start && hold_count < HOLD_CYCLES) begin
            res_ch.ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every accepted result.
    always @(posedge clk) begin
        t_result got;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.write_valid = res_ch.write_valid;
            got.write_row = res_ch.write_row;
            got.write_col = res_ch.write_col;
            got.write_glyph = res_ch.write_glyph;
            got.scroll_up = res_ch.scroll_up;
            got.cursor_row = res_ch.cursor_row;
            got.cursor_col = res_ch.cursor_col;
            tracker.check_result(got);
        end
    end

    // Offer one character request, with a random gap before it.
    task automatic send_char(input logic [CODE_W-1:0] code);
        while ($urandom_range(99) < idle_pct) begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.char_code <= code;
        do @(posedge clk); while (!char_ch.ready);
        tracker.note_char(code);
        chars_sent++;
    endtask

    // Write one register once every owed result is back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        char_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.write_data <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        tracker.set_reg(idx, data);
        reg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Nearly half control characters, so wraps and scrolls come often.
    function automatic logic [CODE_W-1:0] pick_char();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 25) return CHAR_NEWLINE;
        if (sel < 40) return CHAR_TAB;
        if (sel < 48) return CHAR_RETURN;
        return CODE_W'($urandom_range(255));
    endfunction

    initial begin
        logic [CODE_W-1:0] opening [7] = '{8'h00, 8'hFF, 8'h41, CHAR_TAB, CHAR_RETURN,
                                           CHAR_NEWLINE, 8'h7F};
        logic [CODE_W-1:0] narrow [13] = '{CHAR_TAB, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65,
                                           8'h66, 8'h67, 8'h68, 8'h69, CHAR_TAB,
                                           CHAR_NEWLINE, 8'h6A};
        logic [CODE_W-1:0] wide [3] = '{CHAR_TAB, 8'h20, CHAR_NEWLINE};
        int unsigned idle_modes [4] = '{0, 63, 0, 36};
        int unsigned stall_modes [4] = '{0, 0, 63, 36};
        logic [CFG_DATA_W-1:0] rows_pick;
        logic [CFG_DATA_W-1:0] cols_pick;
        int unsigned sel;
        int unsigned waited;

        rst_n <= 1'b0;
        char_ch.valid <= 1'b0;
        char_ch.char_code <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.reg_index <= '0;
        cfg_ch.write_data <= '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_start = 1'b0;
        hold_count = 0;
        chars_sent = 0;
        reg_writes = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset size, then the smallest screen, then the widest.
        foreach (opening[i]) send_char(opening[i]);
        write_reg(REG_SCREEN_ROWS, 8'd0);
        write_reg(REG_SCREEN_COLUMNS, 8'd0);
        foreach (narrow[i]) send_char(narrow[i]);
        write_reg(REG_BEYOND_MAP, 8'd3);
        write_reg(REG_TOP_INDEX, 8'd0);
        send_char(8'h6B);
        write_reg(REG_SCREEN_ROWS, 8'd255);
        write_reg(REG_SCREEN_COLUMNS, 8'd7);
        write_reg(REG_SCREEN_COLUMNS, 8'd255);
        foreach (wide[i]) send_char(wide[i]);

        // Random phases: new screen size and idling mode for each.
        for (int p = 0; p < 10; p++) begin
            sel = $urandom_range(5);
            rows_pick = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd1 : (sel == 2) ? 8'd2 :
                        (sel == 3) ? 8'd255 : CFG_DATA_W'($urandom_range(254, 3));
            sel = $urandom_range(5);
            cols_pick = (sel == 0) ? CFG_DATA_W'($urandom_range(7)) : (sel == 1) ? 8'd8 :
                        (sel == 2) ? 8'd255 : CFG_DATA_W'($urandom_range(254, 9));
            if ($urandom_range(1)) begin
                write_reg(REG_SCREEN_ROWS, rows_pick);
                write_reg(REG_SCREEN_COLUMNS, cols_pick);
            end else begin
                write_reg(REG_SCREEN_COLUMNS, cols_pick);
                write_reg(REG_SCREEN_ROWS, rows_pick);
            end
            if (p % 3 == 2)
                write_reg(CFG_IDX_W'($urandom_range(255, 2)), CFG_DATA_W'($urandom_range(255)));
            idle_pct = idle_modes[p % 4];
            stall_pct = stall_modes[p % 4];
            repeat (60) send_char(pick_char());

            // Hold the result side off while requests keep coming.
            if (p == 4) begin
                idle_pct = 0;
                stall_pct = 0;
                hold_start = 1'b1;
                repeat (50) send_char(pick_char());
            end
        end

        // Drain the owed results, then give the pipeline time to settle.
        char_ch.valid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        waited = 0;
        while (tracker.pending() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);

        $display("covered %0d characters and %0d results over %0d register writes",
                 chars_sent, tracker.checked, reg_writes);
        $display("screen sizes from 1x8 to 255x255, four idling modes, one long result stall");
        if (tracker.failures() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #5ms;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tcce_pkg.sv
rtl/tcce_if.sv
rtl/tcce_cursor_step.sv
rtl/text_console_cursor_engine_core.sv
bench/text_console_cursor_engine_core_test.sv
